// ----- hdl/hrm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and constants for the heartbeat round monitor.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int ID_W        = 3;
  localparam int LAT_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;   // source_id, zero padded
  localparam int OUT_TDATA_W = 24;  // node_id, alive, latency, zero padded

  localparam logic [LAT_W-1:0] LAT_SAT = {LAT_W{1'b1}};

  localparam logic [CFG_DATA_W-1:0] POLL_INTERVAL_RST = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RESP_TIMEOUT_RST  = 16'd2000;

  // input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_RESP = 1'b1;

  // result kind codes
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT  = 1'b1;

  // burst start request from the round logic to the serializer
  typedef struct packed {
    logic load;
    logic kind;
  } hrm_burst_t;

endpackage

// ----- hdl/hrm_ser.sv -----
// ----------------------------------------------------------------------------
// hrm_ser
// Burst serializer: holds a snapshot of one request or report burst and
// plays it out one beat per cycle through the output register while out_tready does not stall it.
// ----------------------------------------------------------------------------
module hrm_ser import hrm_pkg::*; #(
  parameter int NUM_TARGETS = 6,
  parameter int NUM_SELF    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hrm_burst_t       burst,
  input  logic             snap_alive [NUM_TARGETS],
  input  logic [LAT_W-1:0] snap_lat   [NUM_TARGETS],
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ID_W-1:0]  out_id,
  output logic             out_alive,
  output logic [LAT_W-1:0] out_lat,
  output logic             out_kind,
  output logic             out_last
);

  localparam int NUM_NODES = NUM_SELF + NUM_TARGETS;
  localparam int IDX_W     = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

  logic             bb_valid_r;
  logic             bb_kind_r;
  logic [IDX_W-1:0] bb_idx_r;
  logic             bb_alive_r [NUM_TARGETS];
  logic [LAT_W-1:0] bb_lat_r   [NUM_TARGETS];

  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_alive_r;
  logic [LAT_W-1:0] out_lat_r;
  logic             out_kind_r;
  logic             out_last_r;

  logic             load_out;
  logic             last_beat;
  logic [IDX_W:0]   tgt;
  logic             is_self;
  logic [ID_W-1:0]  beat_id;
  logic             beat_alive;
  logic [LAT_W-1:0] beat_lat;

  assign load_out  = bb_valid_r & (~out_valid_r | out_tready);
  assign last_beat = (bb_kind_r == KIND_REPORT)
                   ? ({1'b0, bb_idx_r} == (IDX_W+1)'(NUM_NODES - 1))
                   : ({1'b0, bb_idx_r} == (IDX_W+1)'(NUM_TARGETS - 1));
  assign free      = ~bb_valid_r | (load_out & last_beat);

  // beat decode: requests walk the targets, reports walk self ids then targets
  always_comb begin
    is_self    = 1'b0;
    beat_alive = 1'b0;
    beat_lat   = '0;
    if (bb_kind_r == KIND_REPORT) begin
      is_self = ({1'b0, bb_idx_r} < (IDX_W+1)'(NUM_SELF));
      tgt     = {1'b0, bb_idx_r} - (IDX_W+1)'(NUM_SELF);
      beat_id = ID_W'(bb_idx_r);
    end else begin
      tgt     = {1'b0, bb_idx_r};
      beat_id = ID_W'(32'(bb_idx_r) + NUM_SELF);
    end
    if (bb_kind_r == KIND_REPORT) begin
      if (is_self) begin
        beat_alive = 1'b1;
      end else begin
        for (int i = 0; i < NUM_TARGETS; i++) begin
          if (tgt == (IDX_W+1)'(i) && bb_alive_r[i]) begin
            beat_alive = 1'b1;
            beat_lat   = bb_lat_r[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_valid_r <= 1'b0;
      bb_idx_r   <= '0;
    end else if (burst.load) begin
      bb_valid_r <= 1'b1;
      bb_idx_r   <= '0;
    end else if (load_out) begin
      if (last_beat) begin
        bb_valid_r <= 1'b0;
      end else begin
        bb_idx_r <= bb_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      bb_kind_r <= burst.kind;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        bb_alive_r[i] <= snap_alive[i];
        bb_lat_r[i]   <= snap_lat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id_r    <= beat_id;
      out_alive_r <= beat_alive;
      out_lat_r   <= beat_lat;
      out_kind_r  <= bb_kind_r;
      out_last_r  <= last_beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_id     = out_id_r;
  assign out_alive  = out_alive_r;
  assign out_lat    = out_lat_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

endmodule

// ----- hdl/heartbeat_round_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// heartbeat_round_monitor_unit
// Heartbeat liveness monitor run in polling rounds, driven by tick and
// response transfers; emits request bursts and end-of-round reports.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_*     slave      tuser: action; tdata: source_id
//  out_*    master     tuser: kind; tdata: node_id, alive, latency; tlast
//  cfg_*    write      index 0 poll_interval_ms, index 1 response_timeout_ms
//
//  A new input can follow every cycle while the burst serializer is free.
//  A start sends NUM_TARGETS request beats, an end of round NUM_SELF+NUM_TARGETS
//  report beats, one beat per cycle from the burst serializer unless stalled; the next
//  input is taken in the cycle the last beat enters the output register.
//  Reset is synchronous; all round state clears at once, no clearing pass.
//  out_tready low holds the output register and, once the burst buffer is
//  full, stalls the input side.
// ----------------------------------------------------------------------------
module heartbeat_round_monitor_unit import hrm_pkg::*; #(
  parameter int NUM_TARGETS = 6,
  parameter int NUM_SELF    = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] source_id
  input  logic                   in_tuser,   // [0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] node_id, [3] alive, [19:4] latency
  output logic                   out_tuser,  // [0] kind
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(NUM_TARGETS + 1);

  logic [CFG_DATA_W-1:0] interval_r;
  logic [CFG_DATA_W-1:0] timeout_r;

  logic             pending_r [NUM_TARGETS];
  logic             pending_nxt [NUM_TARGETS];
  logic             alive_r [NUM_TARGETS];
  logic             alive_nxt [NUM_TARGETS];
  logic [LAT_W-1:0] lat_r [NUM_TARGETS];
  logic [LAT_W-1:0] lat_nxt [NUM_TARGETS];
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] pcount_r, pcount_nxt;
  logic             polled_r, polled_nxt;
  logic [LAT_W-1:0] since_poll_r, since_poll_nxt;
  logic [LAT_W-1:0] elapsed_r, elapsed_nxt;

  logic             in_xfer;
  logic [ID_W-1:0]  src;
  logic [LAT_W-1:0] sp_inc;
  logic [LAT_W-1:0] re_inc;
  logic             hit;
  hrm_burst_t       burst;
  logic             ser_free;
  logic [ID_W-1:0]  o_id;
  logic             o_alive;
  logic [LAT_W-1:0] o_lat;

  assign in_xfer = in_tvalid & in_tready;
  assign src     = in_tdata[ID_W-1:0];
  assign sp_inc  = (since_poll_r == LAT_SAT) ? LAT_SAT : since_poll_r + 1'b1;
  assign re_inc  = (elapsed_r == LAT_SAT) ? LAT_SAT : elapsed_r + 1'b1;

  always_comb begin
    pending_nxt    = pending_r;
    alive_nxt      = alive_r;
    lat_nxt        = lat_r;
    active_nxt     = active_r;
    pcount_nxt     = pcount_r;
    polled_nxt     = polled_r;
    since_poll_nxt = since_poll_r;
    elapsed_nxt    = elapsed_r;
    hit            = 1'b0;
    burst.load     = 1'b0;
    burst.kind     = KIND_REPORT;
    if (in_xfer) begin
      if (in_tuser == ACT_TICK) begin
        since_poll_nxt = sp_inc;
        if (active_r) begin
          elapsed_nxt = re_inc;
          if (re_inc >= timeout_r) begin
            // timeout: whatever is still pending is dead
            for (int i = 0; i < NUM_TARGETS; i++) begin
              if (pending_r[i]) begin
                pending_nxt[i] = 1'b0;
                alive_nxt[i]   = 1'b0;
                lat_nxt[i]     = '0;
              end
            end
            active_nxt = 1'b0;
            pcount_nxt = '0;
            burst.load = 1'b1;
          end
        end else if (!polled_r || sp_inc >= interval_r) begin
          polled_nxt     = 1'b1;
          since_poll_nxt = '0;
          elapsed_nxt    = '0;
          active_nxt     = 1'b1;
          pcount_nxt     = CNT_W'(NUM_TARGETS);
          for (int i = 0; i < NUM_TARGETS; i++) begin
            pending_nxt[i] = 1'b1;
            alive_nxt[i]   = 1'b0;
            lat_nxt[i]     = '0;
          end
          burst.load = 1'b1;
          burst.kind = KIND_REQUEST;
        end
      end else begin
        for (int i = 0; i < NUM_TARGETS; i++) begin
          if (32'(src) == 32'(NUM_SELF + i) && pending_r[i]) begin
            hit            = 1'b1;
            pending_nxt[i] = 1'b0;
            alive_nxt[i]   = 1'b1;
            lat_nxt[i]     = elapsed_r;
          end
        end
        if (hit) begin
          if (pcount_r != '0) begin
            pcount_nxt = pcount_r - 1'b1;
          end
          if (pcount_nxt == '0) begin
            active_nxt = 1'b0;
            burst.load = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
        pending_r[i] <= 1'b0;
        alive_r[i]   <= 1'b0;
        lat_r[i]     <= '0;
      end
      active_r     <= 1'b0;
      pcount_r     <= '0;
      polled_r     <= 1'b0;
      since_poll_r <= '0;
      elapsed_r    <= '0;
    end else begin
      pending_r    <= pending_nxt;
      alive_r      <= alive_nxt;
      lat_r        <= lat_nxt;
      active_r     <= active_nxt;
      pcount_r     <= pcount_nxt;
      polled_r     <= polled_nxt;
      since_poll_r <= since_poll_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= POLL_INTERVAL_RST;
      timeout_r  <= RESP_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POLL_INTERVAL: interval_r <= cfg_wdata;
        CFG_RESP_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hrm_ser #(
    .NUM_TARGETS (NUM_TARGETS),
    .NUM_SELF    (NUM_SELF)
  ) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .snap_alive (alive_nxt),
    .snap_lat   (lat_nxt),
    .free       (ser_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_id     (o_id),
    .out_alive  (o_alive),
    .out_lat    (o_lat),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

  assign in_tready = ser_free;
  assign out_tdata = {(OUT_TDATA_W - ID_W - 1 - LAT_W)'(0), o_lat, o_alive, o_id};

endmodule
